// File: rtl/scalar_kalman_filter_assert.svh
// Assertion helpers for the scalar Kalman filter.
// Both forms sample on i_clk and are off while i_rst_n is low.
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SKF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/skf_pkg.sv
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_BITS = 16;
    localparam int ADD_W     = DATA_W + 3;
    localparam int REM_W     = DATA_W + 1;
    localparam int MUL_A_W   = GAIN_BITS + 2;
    localparam int MUL_B_W   = DATA_W + 2;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int CNT_W     = $clog2(GAIN_BITS);
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_BITS-1:0] GAIN_MAX  = '1;
    localparam logic [MUL_A_W-1:0]   GAIN_ONE  = MUL_A_W'(1) << GAIN_BITS;
    localparam logic [DATA_W-1:0]    VAR_RESET = 32'd65536;
    localparam logic [DATA_W-1:0]    Q_RESET   = 32'd655;
    localparam logic [DATA_W-1:0]    R_RESET   = 32'd65536;
    localparam logic [DATA_W-1:0]    S32_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]    S32_MIN   = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

    typedef enum logic [3:0] {
        OP_LOAD, OP_PRIME, OP_ADDQ, OP_ADDR, OP_CHECK, OP_DIV,
        OP_ERR, OP_MULE, OP_UPDE, OP_MULP, OP_UPDP, OP_HOLD
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRIME, ST_ADDQ, ST_ADDR, ST_CHECK, ST_DIV,
        ST_ERR, ST_MULE, ST_UPDE, ST_MULP, ST_UPDP, ST_DONE
    } t_state;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic primed;
        logic skip;     // divider not needed, gain already settled
    } t_stat;

    typedef struct packed {
        logic in_ready;
        logic out_load;
    } t_hs;

endpackage

// File: rtl/skf_seq.sv
module skf_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_out_free,
    input  skf_pkg::t_stat i_stat,
    output skf_pkg::t_ctl  o_ctl,
    output skf_pkg::t_hs   o_hs
);
    import skf_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_stat.primed ? ST_ADDQ : ST_PRIME;
                end
            end
            ST_PRIME: n_state = ST_DONE;
            ST_ADDQ:  n_state = ST_ADDR;
            ST_ADDR:  n_state = ST_CHECK;
            ST_CHECK: n_state = i_stat.skip ? ST_ERR : ST_DIV;
            ST_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(GAIN_BITS - 1)) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR:  n_state = ST_MULE;
            ST_MULE: n_state = ST_UPDE;
            ST_UPDE: n_state = ST_MULP;
            ST_MULP: n_state = ST_UPDP;
            ST_UPDP: n_state = ST_DONE;
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_hs.in_ready = 1'b0;
        o_hs.out_load = 1'b0;
        o_ctl.op      = OP_HOLD;
        case (r_state)
            ST_IDLE: begin
                o_hs.in_ready = 1'b1;
                o_ctl.op      = OP_LOAD;
            end
            ST_PRIME: o_ctl.op = OP_PRIME;
            ST_ADDQ:  o_ctl.op = OP_ADDQ;
            ST_ADDR:  o_ctl.op = OP_ADDR;
            ST_CHECK: o_ctl.op = OP_CHECK;
            ST_DIV:   o_ctl.op = OP_DIV;
            ST_ERR:   o_ctl.op = OP_ERR;
            ST_MULE:  o_ctl.op = OP_MULE;
            ST_UPDE:  o_ctl.op = OP_UPDE;
            ST_MULP:  o_ctl.op = OP_MULP;
            ST_UPDP:  o_ctl.op = OP_UPDP;
            ST_DONE:  o_hs.out_load = i_out_free;
            default:  o_ctl.op = OP_HOLD;
        endcase
    end

endmodule

// File: rtl/skf_datapath.sv
module skf_datapath #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skf_pkg::t_ctl                     i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  logic [skf_pkg::DATA_W-1:0]        i_q,
    input  logic [skf_pkg::DATA_W-1:0]        i_r,
    output skf_pkg::t_stat                    o_stat,
    output logic [skf_pkg::DATA_W-1:0]        o_est
);
    import skf_pkg::*;

    // sample to Q format, saturated to signed 32 bits
    localparam int ZW = SAMPLE_WIDTH + FRAC_BITS;
    localparam int ZX = (ZW > DATA_W) ? ZW : DATA_W + 1;
    localparam logic signed [ZX-1:0] ZMAX = ZX'($signed({1'b0, S32_MAX}));
    localparam logic signed [ZX-1:0] ZMIN = ZX'($signed({1'b1, S32_MIN}));

    logic signed [ZX-1:0] z_wide;
    logic [DATA_W-1:0]    z_sat;

    always_comb begin
        z_wide = ZX'(i_sample) <<< FRAC_BITS;
        if (z_wide > ZMAX) begin
            z_sat = S32_MAX;
        end else if (z_wide < ZMIN) begin
            z_sat = S32_MIN;
        end else begin
            z_sat = z_wide[DATA_W-1:0];
        end
    end

    logic [DATA_W-1:0]    r_x, n_x;
    logic [DATA_W-1:0]    r_p, n_p;
    logic [DATA_W-1:0]    r_z, n_z;
    logic [DATA_W-1:0]    r_d, n_d;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [GAIN_BITS-1:0] r_k, n_k;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                 r_primed, n_primed;

    // shared adder
    logic [ADD_W-1:0] add_a, add_b, add_sum;
    logic             add_cin;
    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    assign add_sum = add_a + add_b + ADD_W'(add_cin);

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (i_ctl.op)
            OP_ADDQ: begin
                add_a = ADD_W'(r_p);
                add_b = ADD_W'(i_q);
            end
            OP_ADDR: begin
                add_a = ADD_W'(r_p);
                add_b = ADD_W'(i_r);
            end
            OP_CHECK: begin
                add_a   = ADD_W'(r_p);
                add_b   = ~ADD_W'(r_d);
                add_cin = 1'b1;
            end
            OP_DIV: begin
                add_a   = ADD_W'({r_rem[DATA_W-1:0], 1'b0});
                add_b   = ~ADD_W'(r_d);
                add_cin = 1'b1;
            end
            OP_ERR: begin
                add_a   = ADD_W'($signed(r_z));
                add_b   = ~ADD_W'($signed(r_x));
                add_cin = 1'b1;
            end
            OP_UPDE: begin
                add_a = ADD_W'($signed(r_x));
                add_b = r_prod[PROD_W-2:GAIN_BITS];
            end
            OP_MULE: begin
                mul_a = $signed(MUL_A_W'(r_k));
                mul_b = MUL_B_W'($signed(r_rem));
            end
            OP_MULP: begin
                mul_a = $signed(GAIN_ONE - MUL_A_W'(r_k));
                mul_b = $signed(MUL_B_W'(r_p));
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    always_comb begin
        n_x      = r_x;
        n_p      = r_p;
        n_z      = r_z;
        n_d      = r_d;
        n_rem    = r_rem;
        n_k      = r_k;
        n_prod   = r_prod;
        n_primed = r_primed;
        o_stat.skip   = 1'b0;
        o_stat.primed = r_primed;
        case (i_ctl.op)
            OP_LOAD: n_z = z_sat;
            OP_PRIME: begin
                n_x      = r_z;
                n_primed = 1'b1;
            end
            OP_ADDQ: n_p = add_sum[DATA_W] ? '1 : add_sum[DATA_W-1:0];
            OP_ADDR: begin
                n_d   = add_sum[DATA_W] ? '1 : add_sum[DATA_W-1:0];
                n_rem = REM_W'(r_p);
            end
            OP_CHECK: begin
                // zero denominator holds the estimate; p >= p+r clamps to max gain
                if (r_d == '0) begin
                    o_stat.skip = 1'b1;
                    n_k         = '0;
                end else if (!add_sum[ADD_W-1]) begin
                    o_stat.skip = 1'b1;
                    n_k         = GAIN_MAX;
                end
            end
            OP_DIV: begin
                if (!add_sum[ADD_W-1]) begin
                    n_rem = add_sum[REM_W-1:0];
                    n_k   = {r_k[GAIN_BITS-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[DATA_W-1:0], 1'b0};
                    n_k   = {r_k[GAIN_BITS-2:0], 1'b0};
                end
            end
            OP_ERR: n_rem = add_sum[REM_W-1:0];
            OP_MULE, OP_MULP: n_prod = mul_a * mul_b;
            OP_UPDE: begin
                if (add_sum[ADD_W-1:DATA_W-1] == '0 || add_sum[ADD_W-1:DATA_W-1] == '1) begin
                    n_x = add_sum[DATA_W-1:0];
                end else begin
                    n_x = add_sum[ADD_W-1] ? S32_MIN : S32_MAX;
                end
            end
            OP_UPDP: n_p = r_prod[DATA_W+GAIN_BITS-1:GAIN_BITS];
            default: n_x = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_p      <= VAR_RESET;
            r_primed <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_p      <= n_p;
            r_primed <= n_primed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z    <= n_z;
        r_d    <= n_d;
        r_rem  <= n_rem;
        r_k    <= n_k;
        r_prod <= n_prod;
    end

    assign o_est = r_x;

endmodule

// File: rtl/scalar_kalman_filter.sv
// Scalar Kalman filter for a stream of signed sensor samples.
//
// Input channel: i_valid / o_ready with i_sample (signed, integer units).
// Output channel: o_valid / i_ready with o_estimate (signed Q16.16).
// Config channel: i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data.
//   Index 0 is process noise q, index 1 is measurement noise r, both
//   unsigned Q16.16; other indexes are dropped. o_cfg_ready is always high.
//   Write only while the filter is idle.
//
// One transaction in gives one transaction out. The first sample after
// reset becomes the estimate. Every later sample runs the 16-step
// restoring divider that forms the gain; when the gain saturates (or
// r+p is zero) the divider is skipped. A new sample is taken only once
// the previous one has been handed to the output register.
// The adder and the multiplier are each a single shared unit stepped by a sequencer.
//
// Reset: q = 655, r = 65536, estimate 0, variance 1.0, filter unprimed.
// The result sits in an output register; while the receiver stalls the
// finished result waits there and the next sample is computed up to the
// point of delivery, then the filter holds until the register frees.
`include "scalar_kalman_filter_assert.svh"

module scalar_kalman_filter #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [skf_pkg::DATA_W-1:0]   o_estimate,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]          i_cfg_data
);
    import skf_pkg::*;

    // configuration registers
    logic [DATA_W-1:0] r_q, r_r;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= Q_RESET;
            r_r <= R_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PROCESS_NOISE: r_q <= i_cfg_data;
                REG_MEASURE_NOISE: r_r <= i_cfg_data;
                default: r_q <= r_q;
            endcase
        end
    end

    t_ctl  ctl;
    t_stat stat;
    t_hs   hs;
    logic  out_free;
    logic [DATA_W-1:0] est;

    // output register
    logic              r_ovalid;
    logic [DATA_W-1:0] r_oest;

    // free when empty or being drained this cycle
    assign out_free = !r_ovalid || i_ready;

    skf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ctl      (ctl),
        .o_hs       (hs)
    );

    skf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_sample (i_sample),
        .i_q      (r_q),
        .i_r      (r_r),
        .o_stat   (stat),
        .o_est    (est)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (hs.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hs.out_load) begin
            r_oest <= est;
        end
    end

    assign o_ready    = hs.in_ready;
    assign o_valid    = r_ovalid;
    assign o_estimate = $signed(r_oest);

    // a sample in flight blocks the next one
    `SKF_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "accepted while busy")
    // a new result never overwrites one still waiting
    `SKF_ASSERT_SAME(a_no_overwrite, hs.out_load, !r_ovalid || i_ready, "result overwritten")
    // a result is loaded only when the sequencer is not taking input
    `SKF_ASSERT_SAME(a_load_not_idle, hs.out_load, !o_ready, "load during idle")

endmodule
